/* sv/oate_pkg.sv */
// ----------------------------------------------------------------------------
// Atom token encoder package
// Shared operation codes, token codes and the queue entry type.
// ----------------------------------------------------------------------------
package oate_pkg;

   // Operation codes carried by an input transaction.
   localparam logic [2:0] OpUint    = 3'd0;
   localparam logic [2:0] OpSint    = 3'd1;
   localparam logic [2:0] OpUid     = 3'd2;
   localparam logic [2:0] OpBinHdr  = 3'd3;
   localparam logic [2:0] OpPayload = 3'd4;

   // Atom token header codes.
   localparam logic [3:0] TokShortUintHi = 4'h8;
   localparam logic [3:0] TokShortSintHi = 4'h9;
   localparam logic [1:0] TokTinySintHi  = 2'b01;
   localparam logic [7:0] TokUid         = 8'hA8;
   localparam logic [3:0] TokHdrShortHi  = 4'hA;
   localparam logic [4:0] TokHdrMediumHi = 5'b11010;
   localparam logic [7:0] TokHdrLong     = 8'hE2;

   // Thresholds between tiny, short, medium and long forms.
   localparam logic [63:0] TinyUintLimit  = 64'h40;
   localparam logic [23:0] HdrShortLimit  = 24'd16;
   localparam logic [23:0] HdrMediumLimit = 24'd2048;

   // Byte counts of fixed-size atom bodies.
   localparam logic [3:0] UidBytes       = 4'd8;
   localparam logic [3:0] MediumHdrBytes = 4'd1;
   localparam logic [3:0] LongHdrBytes   = 4'd3;

   // Queue between the front and back ends.
   localparam int QDepth  = 2;
   localparam int QPtrW   = $clog2(QDepth);
   localparam int QCountW = $clog2(QDepth + 1);

   // One classified token: header byte, body byte count and body bits.
   typedef struct packed {
      logic [7:0]  head;
      logic [3:0]  nbytes;
      logic [63:0] data;
   } qentry_type;

   typedef struct packed {
      logic [QCountW-1:0] level;
      logic               full;
      logic               nonempty;
   } queue_status_type;

   typedef struct packed {
      logic active;
   } back_status_type;

endpackage

/* sv/oate_front.sv */
// ----------------------------------------------------------------------------
// Atom token encoder front end
// Accepts request transactions and classifies them into queue entries.
// ----------------------------------------------------------------------------
module oate_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_operation,
   input  logic [63:0]               req_value,
   input  logic [23:0]               req_length,
   input  oate_pkg::queue_status_type q_status,
   output logic                      push,
   output oate_pkg::qentry_type      push_entry
);

   // Fewest bytes that hold an unsigned value, at least one.
   function automatic logic [3:0] unsigned_len(input logic [63:0] v);
      logic [3:0] n;
      n = 4'd1;
      for (int i = 1; i < 8; i++) begin
         if (v[8*i +: 8] != 8'd0) begin
            n = 4'(i + 1);
         end
      end
      return n;
   endfunction

   // Fewest bytes whose sign extension gives back the value.
   function automatic logic [3:0] signed_len(input logic [63:0] v);
      logic [3:0]  n;
      logic [63:0] hi;
      n = 4'd8;
      for (int i = 7; i >= 1; i--) begin
         hi = 64'($signed(v) >>> (8*i - 1));
         if ((&hi) || !(|hi)) begin
            n = 4'(i);
         end
      end
      return n;
   endfunction

   logic [3:0] ulen;
   logic [3:0] slen;
   logic       sint_tiny;
   logic       op_known;

   assign ulen      = unsigned_len(req_value);
   assign slen      = signed_len(req_value);
   assign sint_tiny = (&req_value[63:5]) || !(|req_value[63:5]);

   // Back pressure comes only from a full queue.
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full && op_known;

   // Classify the operation into a header byte and a body.
   always_comb begin
      op_known        = 1'b1;
      push_entry.head   = req_value[7:0];
      push_entry.nbytes = 4'd0;
      push_entry.data   = req_value;
      unique case (req_operation)
         oate_pkg::OpUint: begin
            if (req_value >= oate_pkg::TinyUintLimit) begin
               push_entry.head   = {oate_pkg::TokShortUintHi, ulen};
               push_entry.nbytes = ulen;
            end
         end
         oate_pkg::OpSint: begin
            if (sint_tiny) begin
               push_entry.head = {oate_pkg::TokTinySintHi, req_value[5:0]};
            end else begin
               push_entry.head   = {oate_pkg::TokShortSintHi, slen};
               push_entry.nbytes = slen;
            end
         end
         oate_pkg::OpUid: begin
            push_entry.head   = oate_pkg::TokUid;
            push_entry.nbytes = oate_pkg::UidBytes;
         end
         oate_pkg::OpBinHdr: begin
            push_entry.data = {40'd0, req_length};
            if (req_length < oate_pkg::HdrShortLimit) begin
               push_entry.head = {oate_pkg::TokHdrShortHi, req_length[3:0]};
            end else if (req_length < oate_pkg::HdrMediumLimit) begin
               push_entry.head   = {oate_pkg::TokHdrMediumHi, req_length[10:8]};
               push_entry.nbytes = oate_pkg::MediumHdrBytes;
            end else begin
               push_entry.head   = oate_pkg::TokHdrLong;
               push_entry.nbytes = oate_pkg::LongHdrBytes;
            end
         end
         oate_pkg::OpPayload: begin
            push_entry.head = req_value[7:0];
         end
         default: begin
            op_known = 1'b0;
         end
      endcase
   end

endmodule

/* sv/oate_queue.sv */
// ----------------------------------------------------------------------------
// Atom token encoder queue
// Short register queue that decouples classification from serialization.
// ----------------------------------------------------------------------------
module oate_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  oate_pkg::qentry_type       push_entry,
   input  logic                       pop,
   output oate_pkg::qentry_type       pop_entry,
   output oate_pkg::queue_status_type q_status
);

   oate_pkg::qentry_type              entries_ff [oate_pkg::QDepth];
   oate_pkg::qentry_type              entries_in [oate_pkg::QDepth];
   logic [oate_pkg::QPtrW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [oate_pkg::QPtrW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [oate_pkg::QCountW-1:0]      count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign q_status.level    = count_ff;
   assign q_status.full     = (count_ff == oate_pkg::QCountW'(oate_pkg::QDepth));
   assign q_status.nonempty = (count_ff != '0);
   assign pop_entry         = entries_ff[rd_ptr_ff];

   assign do_push = push && !q_status.full;
   assign do_pop  = pop && q_status.nonempty;

   // Pointer and fill count update.
   always_comb begin
      entries_in = entries_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (do_push) begin
         entries_in[wr_ptr_ff] = push_entry;
         wr_ptr_in = (wr_ptr_ff == oate_pkg::QPtrW'(oate_pkg::QDepth - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == oate_pkg::QPtrW'(oate_pkg::QDepth - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Control state is reset; the entry storage is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

endmodule

/* sv/oate_back.sv */
// ----------------------------------------------------------------------------
// Atom token encoder back end
// Serializes queue entries into token bytes through an output register.
// ----------------------------------------------------------------------------
module oate_back (
   input  logic                       clock,
   input  logic                       reset,
   input  oate_pkg::queue_status_type q_status,
   input  oate_pkg::qentry_type       pop_entry,
   output logic                       pop,
   output oate_pkg::back_status_type  b_status,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last
);

   logic        valid_ff, valid_in;
   logic        active_ff, active_in;
   logic [3:0]  rem_ff, rem_in;
   logic [63:0] data_ff, data_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        load;
   logic [2:0]  idx;

   assign load            = !valid_ff || !rsp_stall;
   assign idx             = 3'(rem_ff - 4'd1);
   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last        = last_ff;
   assign b_status.active = active_ff;

   // Next byte: continue the body of the current token, else start the next.
   always_comb begin
      valid_in  = valid_ff;
      active_in = active_ff;
      rem_in    = rem_ff;
      data_in   = data_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      if (load) begin
         if (active_ff) begin
            valid_in  = 1'b1;
            byte_in   = data_ff[{idx, 3'b000} +: 8];
            last_in   = (rem_ff == 4'd1);
            rem_in    = rem_ff - 4'd1;
            active_in = (rem_ff != 4'd1);
         end else if (q_status.nonempty) begin
            pop       = 1'b1;
            valid_in  = 1'b1;
            byte_in   = pop_entry.head;
            last_in   = (pop_entry.nbytes == 4'd0);
            rem_in    = pop_entry.nbytes;
            data_in   = pop_entry.data;
            active_in = (pop_entry.nbytes != 4'd0);
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         active_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      data_ff <= data_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule

/* sv/opal_atom_token_encoder.sv */
// ----------------------------------------------------------------------------
// Opal atom token encoder
// Turns integer, UID, binary header and payload requests into atom tokens.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  req_operation, req_value, req_length
//   rsp      out        rsp_valid / rsp_stall  rsp_out_byte, rsp_last
//
// Each transaction yields one to nine bytes, one byte per cycle from the
// output register while rsp_stall is low. The front end classifies in the
// cycle of acceptance into a two-entry queue; it stalls only while that
// queue is full. Unknown operations are accepted and dropped. Reset is
// synchronous and empties the queue and output register.
module opal_atom_token_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [63:0] req_value,
   input  logic [23:0] req_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last
);

   oate_pkg::queue_status_type q_status;
   oate_pkg::back_status_type  b_status;
   oate_pkg::qentry_type       push_entry;
   oate_pkg::qentry_type       pop_entry;
   logic                       push;
   logic                       pop;

   // Classification of incoming transactions.
   oate_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_value     (req_value),
      .req_length    (req_length),
      .q_status      (q_status),
      .push          (push),
      .push_entry    (push_entry)
   );

   // Decoupling queue.
   oate_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   // Byte serializer.
   oate_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .pop_entry    (pop_entry),
      .pop          (pop),
      .b_status     (b_status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

`ifndef SYNTHESIS
   // The queue never holds more entries than it has.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.level <= oate_pkg::QCountW'(oate_pkg::QDepth))
      else $error("queue level exceeds depth");

   // A token body in progress always has a byte waiting at the output.
   a_active_valid: assert property (@(posedge clock) disable iff (reset)
      b_status.active |-> rsp_valid)
      else $error("serializer active without output byte");

   // A delivered byte that is not last is followed at once by another byte.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=> rsp_valid)
      else $error("gap inside a token");
`endif

endmodule

/* test/opal_atom_token_encoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Atom token encoder testbench
// Drives integer, UID, binary header, payload and unused requests through the
// encoder with random idle on both channels. Every accepted request is encoded
// here into the expected token bytes, and each byte leaving the block is
// compared in order against them.
// ----------------------------------------------------------------------------
module opal_atom_token_encoder_tb;

   // Operation codes that the block accepts and drops.
   localparam logic [2:0] OpUnused5 = 3'd5;
   localparam logic [2:0] OpUnused6 = 3'd6;
   localparam logic [2:0] OpUnused7 = 3'd7;

   localparam int ResetCycles  = 11;
   localparam int RandomItems  = 186;
   localparam int DrainCycles  = 6;
   localparam int SettleCycles = 24;
   localparam int CycleLimit   = 400000;
   localparam int PrintLimit   = 100;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } token_byte_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_operation;
   logic [63:0] req_value;
   logic [23:0] req_length;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;

   token_byte_type pending_tokens[$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   int             rsp_hold = 0;
   bit             send_idle = 1'b1;
   bit             recv_idle = 1'b1;

   opal_atom_token_encoder dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_operation(req_operation),
      .req_value    (req_value),
      .req_length   (req_length),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic flag_mismatch(input string msg);
      mismatch_count = mismatch_count + 1;
      if (mismatch_count <= PrintLimit)
         $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
   endtask

   // Token bytes that one request must produce, appended to the expected stream.
   task automatic encode_atom(input logic [2:0] op, input logic [63:0] v,
                              input logic [23:0] len);
      logic [7:0]         head;
      bit                 known;
      logic [63:0]        field;
      logic signed [63:0] s;
      logic signed [63:0] shifted;
      int                 n;
      int                 nb;
      token_byte_type     tok;
      s = v;
      field = v;
      nb = 0;
      head = 8'h00;
      known = 1'b1;
      case (op)
         oate_pkg::OpUint: begin
            if (v < oate_pkg::TinyUintLimit) begin
               head = v[7:0];
            end else begin
               nb = 8;
               while (nb > 1 && v[8*(nb-1) +: 8] == 8'h00)
                  nb = nb - 1;
               head = {oate_pkg::TokShortUintHi, 4'(nb)};
            end
         end
         oate_pkg::OpSint: begin
            shifted = s >>> 5;
            if (&shifted || ~|shifted) begin
               head = {oate_pkg::TokTinySintHi, v[5:0]};
            end else begin
               // Fewest bytes whose sign extension gives back the value.
               nb = 8;
               for (n = 7; n >= 1; n--) begin
                  shifted = s >>> (8 * n - 1);
                  if (&shifted || ~|shifted)
                     nb = n;
               end
               head = {oate_pkg::TokShortSintHi, 4'(nb)};
            end
         end
         oate_pkg::OpUid: begin
            head = oate_pkg::TokUid;
            nb = 8;
         end
         oate_pkg::OpBinHdr: begin
            field = {40'd0, len};
            if (len < oate_pkg::HdrShortLimit) begin
               head = {oate_pkg::TokHdrShortHi, len[3:0]};
            end else if (len < oate_pkg::HdrMediumLimit) begin
               head = {oate_pkg::TokHdrMediumHi, len[10:8]};
               nb = 1;
            end else begin
               head = oate_pkg::TokHdrLong;
               nb = 3;
            end
         end
         oate_pkg::OpPayload: begin
            head = v[7:0];
         end
         default: begin
            known = 1'b0;
         end
      endcase
      // The header byte comes first, then the body most significant first.
      if (known) begin
         tok.data = head;
         tok.last = (nb == 0);
         pending_tokens.insert(pending_tokens.size(), tok);
         for (n = nb - 1; n >= 0; n--) begin
            tok.data = field[8*n +: 8];
            tok.last = (n == 0);
            pending_tokens.insert(pending_tokens.size(), tok);
         end
      end
   endtask

   // Send one request transaction after a random gap and record its tokens.
   task automatic issue_request(input logic [2:0] op, input logic [63:0] v,
                                input logic [23:0] len);
      int gap;
      gap = send_idle ? $urandom_range(0, 13) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= v;
      req_length    <= len;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      encode_atom(op, v, len);
   endtask

   // Hold the request side quiet until the expected stream is empty.
   task automatic pause_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_tokens.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Check each accepted result byte against the oldest expected one.
   always @(posedge clock) begin
      token_byte_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_tokens.size() == 0) begin
            flag_mismatch($sformatf("unexpected byte %02h last %b", rsp_out_byte, rsp_last));
         end else begin
            want = pending_tokens.pop_front();
            if (rsp_out_byte !== want.data)
               flag_mismatch($sformatf("out_byte %02h, expected %02h", rsp_out_byte,
                                       want.data));
            if (rsp_last !== want.last)
               flag_mismatch($sformatf("last %b, expected %b (byte %02h)", rsp_last,
                                       want.last, want.data));
         end
         rsp_hold = recv_idle ? $urandom_range(0, 13) : 0;
      end
   end

   // Receiver stall: hold off after each byte until the drawn rsp_hold runs out.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic test_uint_forms();
      issue_request(oate_pkg::OpUint, 64'd0, 24'd0);
      issue_request(oate_pkg::OpUint, 64'h3f, 24'd0);
      issue_request(oate_pkg::OpUint, 64'h40, 24'd0);
      issue_request(oate_pkg::OpUint, 64'h100, 24'd0);
      issue_request(oate_pkg::OpUint, 64'hffff_ffff_ffff_ffff, 24'hffffff);
   endtask

   task automatic test_sint_forms();
      issue_request(oate_pkg::OpSint, -64'sd32, 24'd0);
      issue_request(oate_pkg::OpSint, 64'd31, 24'd0);
      issue_request(oate_pkg::OpSint, 64'd32, 24'd0);
      issue_request(oate_pkg::OpSint, -64'sd33, 24'd0);
      issue_request(oate_pkg::OpSint, 64'h8000_0000_0000_0000, 24'd0);
      issue_request(oate_pkg::OpSint, 64'h7fff_ffff_ffff_ffff, 24'd0);
   endtask

   task automatic test_uid();
      issue_request(oate_pkg::OpUid, 64'd0, 24'd0);
      issue_request(oate_pkg::OpUid, 64'hffff_ffff_ffff_ffff, 24'h5a5a5a);
   endtask

   task automatic test_header_forms();
      issue_request(oate_pkg::OpBinHdr, 64'd0, 24'd0);
      issue_request(oate_pkg::OpBinHdr, 64'd0, 24'd15);
      issue_request(oate_pkg::OpBinHdr, 64'd0, 24'd16);
      issue_request(oate_pkg::OpBinHdr, 64'hffff_ffff_ffff_ffff, 24'd2047);
      issue_request(oate_pkg::OpBinHdr, 64'd0, 24'd2048);
      issue_request(oate_pkg::OpBinHdr, 64'd0, 24'hffffff);
   endtask

   task automatic test_payload();
      issue_request(oate_pkg::OpPayload, 64'd0, 24'd0);
      issue_request(oate_pkg::OpPayload, 64'hffff_ffff_ffff_ffff, 24'd7);
   endtask

   // Unused codes are dropped; a drain afterwards shows nothing leaked out.
   task automatic test_unused_ops();
      issue_request(OpUnused5, 64'h1234, 24'd3);
      issue_request(OpUnused6, 64'hffff_ffff_ffff_ffff, 24'hffffff);
      issue_request(OpUnused7, 64'd0, 24'd0);
      pause_for_drain();
   endtask

   task automatic test_random();
      logic [2:0]  op;
      logic [63:0] v;
      logic [23:0] len;
      int          r;
      int          k;
      int          near;
      for (int idx = 0; idx < RandomItems; idx++) begin
         // Change the idle pattern now and then, with some fully busy stretches.
         if (idx % 30 == 0) begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
         end
         if (idx == RandomItems / 2)
            pause_for_drain();
         r = $urandom_range(0, 99);
         if (r < 20)
            op = oate_pkg::OpUint;
         else if (r < 40)
            op = oate_pkg::OpSint;
         else if (r < 52)
            op = oate_pkg::OpUid;
         else if (r < 75)
            op = oate_pkg::OpBinHdr;
         else if (r < 94)
            op = oate_pkg::OpPayload;
         else if (r < 96)
            op = OpUnused5;
         else if (r < 98)
            op = OpUnused6;
         else
            op = OpUnused7;
         // Values of every byte width, both signs, and some near the tiny edges.
         k = $urandom_range(0, 8);
         v = {$urandom, $urandom};
         if (k < 8)
            v = v & ~(64'hffff_ffff_ffff_ffff << (8 * k));
         if ($urandom_range(0, 1) == 1)
            v = ~v;
         if ($urandom_range(0, 4) == 0) begin
            near = $urandom_range(0, 160);
            v = longint'(near - 80);
         end
         case ($urandom_range(0, 3))
            0: len = 24'($urandom_range(0, 15));
            1: len = 24'($urandom_range(16, 2047));
            2: len = 24'($urandom_range(2048, 24'hffffff));
            default: len = 24'($urandom);
         endcase
         issue_request(op, v, len);
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = oate_pkg::OpUint;
      req_value     = 64'd0;
      req_length    = 24'd0;
      rsp_stall     = 1'b0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_uint_forms();
      test_sint_forms();
      test_uid();
      test_header_forms();
      test_payload();
      test_unused_ops();
      test_random();

      pause_for_drain();
      repeat (SettleCycles) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
